[src/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low
`define LONN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same, on the default clock and reset names
`define LONN_ASSERT_DEF(lbl, prop) \
  `LONN_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

[src/lonn_pkg.sv]
// Types and constants for the leave-one-out nearest-neighbor accuracy block
`default_nettype none
package lonn_pkg;
  localparam int MaxRows     = 512;
  localparam int NumFeatures = 10;
  localparam int FeatW       = 16;
  localparam int LabelW      = 4;
  localparam int CountW      = 10;
  localparam int AddrW       = $clog2(MaxRows);
  localparam int FIdxW       = $clog2(NumFeatures);
  localparam int SqW         = 32;
  localparam int AccW        = SqW + $clog2(NumFeatures);

  typedef struct packed {
    logic [LabelW-1:0] class_label;
    logic signed [FeatW-1:0] feature_0;
    logic signed [FeatW-1:0] feature_1;
    logic signed [FeatW-1:0] feature_2;
    logic signed [FeatW-1:0] feature_3;
    logic signed [FeatW-1:0] feature_4;
    logic signed [FeatW-1:0] feature_5;
    logic signed [FeatW-1:0] feature_6;
    logic signed [FeatW-1:0] feature_7;
    logic signed [FeatW-1:0] feature_8;
    logic signed [FeatW-1:0] feature_9;
    logic last_row;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] correct_count;
    logic [CountW-1:0] row_count;
  } out_t;

  typedef struct packed {
    logic [LabelW-1:0] label;
    logic [NumFeatures-1:0][FeatW-1:0] feat;
  } row_t;

  localparam int RowW = $bits(row_t);

  function automatic row_t to_row(in_t d);
    row_t r;
    r.label   = d.class_label;
    r.feat[0] = d.feature_0;
    r.feat[1] = d.feature_1;
    r.feat[2] = d.feature_2;
    r.feat[3] = d.feature_3;
    r.feat[4] = d.feature_4;
    r.feat[5] = d.feature_5;
    r.feat[6] = d.feature_6;
    r.feat[7] = d.feature_7;
    r.feat[8] = d.feature_8;
    r.feat[9] = d.feature_9;
    return r;
  endfunction
endpackage
`default_nettype wire

[src/lonn_ram.sv]
// Generic single-port-write, registered-read RAM
`default_nettype none
module lonn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[src/leave_one_out_nn_accuracy.sv]
// A row without last_row is written into the row RAM, and the block stays ready.
// On last_row all N stored rows are scored pairwise by one shared multiplier,
//   each pair in steps: RAM read, capture, one feature per cycle, compare;
//   no row is taken until the result is issued.
// The row RAM has no reset; the row count, mask, control and all other registers reset.
// Reset (rst_ni low, asynchronous): mask = all ones, row count = 0.
`default_nettype none
module leave_one_out_nn_accuracy import lonn_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_t                   out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [NumFeatures-1:0] cfg_data_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_RDI, S_WAITI, S_RDJ, S_CAPJ, S_ACC, S_CMP, S_FIN
  } state_e;

  state_e                 state_q;
  logic [CountW-1:0]      cnt_q, n_q, i_q, j_q, correct_q;
  logic [NumFeatures-1:0] mask_q;
  logic [FIdxW-1:0]       f_q;
  logic [AccW-1:0]        acc_q, best_q;
  logic                   found_q;
  logic [LabelW-1:0]      best_label_q;
  row_t                   row_i_q, row_j_q;
  logic [RowW-1:0]        rdata;
  logic [AddrW-1:0]       raddr;
  logic                   wr_en, in_xfer, res_done;
  logic signed [FeatW:0]  diff;
  logic signed [2*FeatW+1:0] sq;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign wr_en       = in_xfer && (cnt_q < CountW'(MaxRows));
  assign raddr       = (state_q == S_RDI) ? i_q[AddrW-1:0] : j_q[AddrW-1:0];
  assign res_done    = (state_q == S_FIN) && (i_q + 1'b1 == n_q);

  // One feature difference squared per cycle
  assign diff = $signed({row_i_q.feat[f_q][FeatW-1], row_i_q.feat[f_q]}) -
                $signed({row_j_q.feat[f_q][FeatW-1], row_j_q.feat[f_q]});
  assign sq   = diff * diff;

  lonn_ram #(.Width(RowW), .Depth(MaxRows)) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(cnt_q[AddrW-1:0]),
    .wdata_i(to_row(in_data_i)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      n_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      correct_q    <= '0;
      mask_q       <= '1;
      f_q          <= '0;
      acc_q        <= '0;
      best_q       <= '0;
      found_q      <= 1'b0;
      best_label_q <= '0;
      row_i_q      <= '0;
      row_j_q      <= '0;
      out_valid_o  <= 1'b0;
      out_data_o   <= '0;
    end else begin
      if (cfg_valid_i) begin
        mask_q <= cfg_data_i;
      end
      // drop the transfer unless a new result replaces it this cycle
      if (out_valid_o && !out_stall_i && !res_done) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_data_i.last_row) begin
              n_q       <= wr_en ? cnt_q + 1'b1 : cnt_q;
              cnt_q     <= '0;
              i_q       <= '0;
              correct_q <= '0;
              state_q   <= S_RDI;
            end else if (wr_en) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_RDI: state_q <= S_WAITI;
        S_WAITI: begin
          row_i_q <= rdata;
          j_q     <= '0;
          found_q <= 1'b0;
          state_q <= S_RDJ;
        end
        S_RDJ: begin
          if (j_q == i_q) begin
            // skip the row itself
            j_q <= j_q + 1'b1;
            if (j_q + 1'b1 == n_q) state_q <= S_FIN;
          end else begin
            state_q <= S_CAPJ;
          end
        end
        S_CAPJ: begin
          row_j_q <= rdata;
          f_q     <= '0;
          acc_q   <= '0;
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (mask_q[f_q]) begin
            acc_q <= acc_q + AccW'(sq[SqW-1:0]);
          end
          f_q <= f_q + 1'b1;
          if (f_q == FIdxW'(NumFeatures - 1)) state_q <= S_CMP;
        end
        S_CMP: begin
          if (!found_q || acc_q < best_q) begin
            found_q      <= 1'b1;
            best_q       <= acc_q;
            best_label_q <= row_j_q.label;
          end
          j_q <= j_q + 1'b1;
          state_q <= (j_q + 1'b1 == n_q) ? S_FIN : S_RDJ;
        end
        S_FIN: begin
          // hold while a previous result is still waiting
          if (!(out_valid_o && out_stall_i)) begin
            if (i_q + 1'b1 == n_q) begin
              out_valid_o              <= 1'b1;
              out_data_o.correct_count <= correct_q +
                  CountW'(found_q && best_label_q == row_i_q.label);
              out_data_o.row_count     <= n_q;
              state_q                  <= S_IDLE;
            end else begin
              if (found_q && best_label_q == row_i_q.label) begin
                correct_q <= correct_q + 1'b1;
              end
              i_q     <= i_q + 1'b1;
              state_q <= S_RDI;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/lonn_checker.sv]
// Port-level checker for the nearest-neighbor accuracy block, with its bind
`default_nettype none
`include "assert_macros.svh"
module lonn_checker import lonn_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);
  `LONN_ASSERT_DEF(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `LONN_ASSERT_DEF(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o))
  `LONN_ASSERT_DEF(a_count_le, out_valid_o |-> out_data_o.correct_count <= out_data_o.row_count)
  `LONN_ASSERT_DEF(a_rows_nz, $rose(out_valid_o) |-> out_data_o.row_count != '0)
  `LONN_ASSERT_DEF(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i)
endmodule

bind leave_one_out_nn_accuracy lonn_checker u_lonn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

[bench/tb.sv]
// Testbench for the leave-one-out nearest-neighbor accuracy block
`timescale 1ns / 100ps
`default_nettype none
module tb import lonn_pkg::*;;
  localparam int LongRun = 12_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [NumFeatures-1:0] cfg_data_i = '0;

  leave_one_out_nn_accuracy uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  logic [LabelW-1:0] label_mem [MaxRows];
  logic signed [FeatW-1:0] feat_mem [MaxRows][NumFeatures];
  int unsigned rows_held = 0;
  logic [NumFeatures-1:0] mask_model = '1;
  out_t score_q[$];

  int fails = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 0;
  bit hold_seen = 0;
  int hold_left = 0;
  longint cycles = 0;

  function automatic longint unsigned pair_dist(int a, int b);
    longint unsigned sum;
    longint signed d;
    sum = 0;
    for (int f = 0; f < NumFeatures; f++) begin
      if (mask_model[f]) begin
        d = longint'(feat_mem[a][f]) - longint'(feat_mem[b][f]);
        sum += longint'(d * d);
      end
    end
    return sum;
  endfunction

  function automatic out_t score_set(int n);
    out_t r;
    int hits;
    bit found;
    longint unsigned best, d;
    logic [LabelW-1:0] best_lbl;
    hits = 0;
    for (int i = 0; i < n; i++) begin
      found = 0;
      best = 0;
      best_lbl = '0;
      for (int j = 0; j < n; j++) begin
        if (j != i) begin
          d = pair_dist(i, j);
          // first row at the minimum keeps the win
          if (!found || d < best) begin
            found = 1;
            best = d;
            best_lbl = label_mem[j];
          end
        end
      end
      if (found && best_lbl == label_mem[i]) hits++;
    end
    r.correct_count = hits[CountW-1:0];
    r.row_count = n[CountW-1:0];
    return r;
  endfunction

  function automatic void absorb_row(in_t r);
    logic signed [FeatW-1:0] f [NumFeatures];
    f = '{r.feature_0, r.feature_1, r.feature_2, r.feature_3, r.feature_4,
          r.feature_5, r.feature_6, r.feature_7, r.feature_8, r.feature_9};
    if (rows_held < MaxRows) begin
      label_mem[rows_held] = r.class_label;
      for (int k = 0; k < NumFeatures; k++) feat_mem[rows_held][k] = f[k];
      rows_held++;
    end
    if (r.last_row) begin
      score_q.push_back(score_set(rows_held));
      rows_held = 0;
    end
  endfunction

  function automatic in_t make_row(logic [LabelW-1:0] lbl,
                                   logic [FeatW-1:0] f [NumFeatures], bit last);
    return {lbl, f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], last};
  endfunction

  // Random row: half fully random, half clustered around a label center
  function automatic in_t rand_row(bit last);
    logic [FeatW-1:0] f [NumFeatures];
    logic [LabelW-1:0] lbl;
    bit wide;
    wide = 1'($urandom_range(1));
    lbl = wide ? LabelW'($urandom) : LabelW'($urandom_range(3));
    for (int k = 0; k < NumFeatures; k++)
      f[k] = wide ? FeatW'($urandom)
                  : FeatW'(int'(lbl) * 4096 - 6000 + $urandom_range(2000));
    return make_row(lbl, f, last);
  endfunction

  task automatic send_row(in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_row(r);
  endtask

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_row(rand_row(i == n - 1));
  endtask

  // Drop valid and wait out every pending score
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [NumFeatures-1:0] m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mask_model = m;
  endtask

  task automatic test_lone_row;
    send_set(1);
  endtask

  task automatic test_extremes;
    logic [FeatW-1:0] f [NumFeatures];
    for (int k = 0; k < NumFeatures; k++) f[k] = 16'h7fff;
    send_row(make_row(4'hf, f, 1'b0));
    for (int k = 0; k < NumFeatures; k++) f[k] = 16'h8000;
    send_row(make_row(4'h0, f, 1'b0));
    for (int k = 0; k < NumFeatures; k++) f[k] = 16'h0000;
    send_row(make_row(4'hf, f, 1'b0));
    for (int k = 0; k < NumFeatures; k++) f[k] = 16'hffff;
    send_row(make_row(4'h0, f, 1'b1));
  endtask

  // Row 0 sits at equal distance from rows 1, 2 and 3; labels split the tie
  task automatic test_ties;
    logic [FeatW-1:0] f [NumFeatures];
    for (int k = 0; k < NumFeatures; k++) f[k] = 16'h0000;
    send_row(make_row(4'h3, f, 1'b0));
    f[0] = 16'h0100;
    send_row(make_row(4'h3, f, 1'b0));
    f[0] = 16'hff00;
    send_row(make_row(4'h5, f, 1'b0));
    f[0] = 16'h0100;
    send_row(make_row(4'h5, f, 1'b1));
  endtask

  task automatic test_masks;
    write_mask('0);
    send_set(4);
    write_mask(10'h001);
    send_set(5);
    write_mask(10'h200);
    send_set(3);
    write_mask('1);
  endtask

  task automatic test_random;
    for (int s = 0; s < 4; s++) begin
      if (s % 4 == 0) write_mask(NumFeatures'($urandom));
      send_set($urandom_range(1, 3));
    end
  endtask

  // Hold the result side off while sets keep coming, so the input stalls
  task automatic test_backpressure;
    hold_go <= ~hold_go;
    for (int s = 0; s < 8; s++) send_set(2);
    drain();
  endtask

  task automatic test_store_full;
    write_mask(NumFeatures'($urandom));
    send_set(MaxRows + 2);
  endtask

  task automatic set_idling(int snd, int rcv);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
  endtask

  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (score_q.size() == 0) begin
        $error("unexpected result %0d/%0d", out_data_o.correct_count,
               out_data_o.row_count);
        fails++;
      end else begin
        exp_r = score_q.pop_front();
        if (out_data_o.correct_count !== exp_r.correct_count) begin
          $error("correct_count: expected %0d, got %0d", exp_r.correct_count,
                 out_data_o.correct_count);
          fails++;
        end
        if (out_data_o.row_count !== exp_r.row_count) begin
          $error("row_count: expected %0d, got %0d", exp_r.row_count,
                 out_data_o.row_count);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LongRun) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(0, 0);
    test_lone_row();
    test_extremes();
    test_ties();
    test_masks();
    test_random();
    set_idling(85, 0);
    test_random();
    set_idling(0, 85);
    test_random();
    set_idling(31, 31);
    test_random();
    set_idling(0, 0);
    test_backpressure();
    test_random();
    test_store_full();
    drain();
    repeat (100) @(posedge clk_i);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
